/* hdl/ffpa_pkg.sv */
// Shared constants, types and result codes of the first-fit pool allocator.
package ffpa_pkg;

   localparam int POOL_BYTES_DEF   = 1024;
   localparam int HEADER_BYTES_DEF = 24;
   localparam int MAX_BLOCKS_DEF   = 32;

   localparam int REQ_W    = 16;
   localparam int STATUS_W = 2;
   localparam int OFFSET_W = 10;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_GRANTED  = 2'd0,
      STATUS_BAD_SIZE = 2'd1,
      STATUS_NO_FIT   = 2'd2
   } status_type;

   // Decisions of the step unit for the table entry under evaluation.
   typedef struct packed {
      logic fit;        // free and large enough
      logic whole;      // grant without splitting
      logic split_oob;  // split header and data would pass pool end
      logic data_ok;    // granted data stays inside the pool
      logic stop;       // walk ends after this entry
   } step_flags_type;

endpackage

/* hdl/ffpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ffpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/ffpa_step.sv */
// Shared step unit: evaluates one block table entry of the first-fit walk.
module ffpa_step #(
   parameter int POOL_BYTES   = ffpa_pkg::POOL_BYTES_DEF,
   parameter int HEADER_BYTES = ffpa_pkg::HEADER_BYTES_DEF,
   parameter int SW           = 11,
   parameter int PW           = 13
) (
   input  logic [PW-1:0]              pos,
   input  logic [SW-1:0]              need,
   input  logic [SW-1:0]              block_size,
   input  logic                       block_used,
   input  logic                       table_full,
   input  logic                       last_entry,
   output ffpa_pkg::step_flags_type   flags,
   output logic [PW-1:0]              next_pos,
   output logic [PW-1:0]              data_offset,
   output logic [SW-1:0]              tail_size
);

   localparam logic [PW-1:0] HDR_P  = PW'(HEADER_BYTES);
   localparam logic [PW-1:0] POOL_P = PW'(POOL_BYTES);
   localparam logic [SW-1:0] HDR_S  = SW'(HEADER_BYTES);

   logic [PW-1:0] need_p;
   logic [PW-1:0] size_p;
   logic [PW-1:0] data_end;

   assign need_p      = PW'(need);
   assign size_p      = PW'(block_size);
   assign next_pos    = pos + HDR_P + size_p;
   assign data_offset = pos + HDR_P;
   assign data_end    = data_offset + need_p;
   assign tail_size   = block_size - need - HDR_S;

   assign flags.fit       = !block_used && (size_p >= need_p);
   assign flags.whole     = (size_p <= need_p + HDR_P) || table_full;
   assign flags.split_oob = (data_end + HDR_P) > POOL_P;
   assign flags.data_ok   = data_end <= POOL_P;
   assign flags.stop      = last_entry || ((next_pos + HDR_P) > POOL_P);

endmodule

/* hdl/first_fit_pool_allocator.sv */
// Top level of the first-fit pool allocator: walk sequencer, block table and result register.
//
// Usage:
//   Request channel (req_valid / req_stall / req_request_bytes) carries one allocation
//   size in bytes; it is rounded up to a multiple of 8. Each request gives exactly one
//   response on rsp_valid / rsp_stall with rsp_status (granted, bad size, no fit) and
//   rsp_data_offset (byte offset of the data area, 0 unless granted).
//   Only one request is in flight: req_stall is high from the transfer until the
//   sequencer returns to idle.
//   A bad size is answered without a walk. A walk visits one table entry per cycle
//   (one read of the table RAM per cycle through the shared step unit) and stops at the
//   first free entry that is large enough, or at the end of the table or pool. A split
//   first moves each later entry up one place in the table (a read and a write per
//   entry), then writes the tail and head entries.
//   Reset: synchronous; for one cycle after reset the sequencer writes the initial free
//   block into table entry 0 and holds req_stall high.
//   A stalled response is held in the output register; the next request is still taken
//   and walked, and its result waits in the sequencer until the register is free.
module first_fit_pool_allocator #(
   parameter int POOL_BYTES   = ffpa_pkg::POOL_BYTES_DEF,
   parameter int HEADER_BYTES = ffpa_pkg::HEADER_BYTES_DEF,
   parameter int MAX_BLOCKS   = ffpa_pkg::MAX_BLOCKS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ffpa_pkg::REQ_W-1:0]    req_request_bytes,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ffpa_pkg::STATUS_W-1:0] rsp_status,
   output logic [ffpa_pkg::OFFSET_W-1:0] rsp_data_offset
);

   localparam int SW     = $clog2(POOL_BYTES + 1);
   localparam int PW     = (SW + 2 > ffpa_pkg::OFFSET_W) ? SW + 2 : ffpa_pkg::OFFSET_W;
   localparam int IW     = $clog2(MAX_BLOCKS);
   localparam int CW     = $clog2(MAX_BLOCKS + 1);
   localparam int WORD_W = SW + 1;
   localparam int NW     = ffpa_pkg::REQ_W + 1;

   localparam logic [NW-1:0] ROUND_ADD  = NW'(7);
   localparam logic [NW-1:0] ROUND_MASK = ~NW'(7);
   localparam logic [NW-1:0] POOL_N     = NW'(POOL_BYTES);
   localparam logic [SW-1:0] INIT_SIZE  = SW'(POOL_BYTES - HEADER_BYTES);
   localparam logic [CW-1:0] MAX_C      = CW'(MAX_BLOCKS);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_WALK,
      ST_SH_RD,
      ST_SH_WR,
      ST_TAIL,
      ST_HEAD,
      ST_DONE
   } state_type;

   state_type                    state_ff,      state_in;
   logic [CW-1:0]                count_ff,      count_in;
   logic [IW-1:0]                idx_ff,        idx_in;
   logic [IW-1:0]                k_ff,          k_in;
   logic [PW-1:0]                pos_ff,        pos_in;
   logic [SW-1:0]                need_ff,       need_in;
   logic [SW-1:0]                tail_ff,       tail_in;
   ffpa_pkg::status_type         status_ff,     status_in;
   logic [ffpa_pkg::OFFSET_W-1:0] offset_ff,    offset_in;
   logic                         rsp_valid_ff,  rsp_valid_in;
   ffpa_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [ffpa_pkg::OFFSET_W-1:0] rsp_off_ff,   rsp_off_in;

   logic                 ram_we;
   logic [IW-1:0]        ram_waddr;
   logic [WORD_W-1:0]    ram_wdata;
   logic [IW-1:0]        ram_raddr;
   logic [WORD_W-1:0]    ram_rdata;

   logic [NW-1:0]        need_round;
   logic [CW-1:0]        next_idx;
   logic [CW-1:0]        k_dec;
   logic                 table_full;
   logic                 last_entry;

   ffpa_pkg::step_flags_type step_flags;
   logic [PW-1:0]        step_next_pos;
   logic [PW-1:0]        step_offset;
   logic [SW-1:0]        step_tail;

   ffpa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ffpa_step #(
      .POOL_BYTES   (POOL_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .SW           (SW),
      .PW           (PW)
   ) u_step (
      .pos         (pos_ff),
      .need        (need_ff),
      .block_size  (ram_rdata[SW-1:0]),
      .block_used  (ram_rdata[SW]),
      .table_full  (table_full),
      .last_entry  (last_entry),
      .flags       (step_flags),
      .next_pos    (step_next_pos),
      .data_offset (step_offset),
      .tail_size   (step_tail)
   );

   assign need_round = ({1'b0, req_request_bytes} + ROUND_ADD) & ROUND_MASK;
   assign next_idx   = CW'(idx_ff) + CW'(1);
   assign k_dec      = CW'(k_ff) - CW'(1);
   assign table_full = count_ff >= MAX_C;
   assign last_entry = next_idx >= count_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      pos_in        = pos_ff;
      need_in       = need_ff;
      tail_in       = tail_ff;
      status_in     = status_ff;
      offset_in     = offset_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = '0;
      ram_raddr     = next_idx[IW-1:0];

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = {1'b0, INIT_SIZE};
            count_in  = CW'(1);
            state_in  = ST_IDLE;
         end
         ST_IDLE: begin
            ram_raddr = '0;
            if (req_valid) begin
               idx_in  = '0;
               pos_in  = '0;
               need_in = need_round[SW-1:0];
               if (need_round == '0 || need_round > POOL_N) begin
                  status_in = ffpa_pkg::STATUS_BAD_SIZE;
                  offset_in = '0;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (step_flags.fit) begin
               if (step_flags.data_ok) begin
                  status_in = ffpa_pkg::STATUS_GRANTED;
                  offset_in = step_offset[ffpa_pkg::OFFSET_W-1:0];
               end else begin
                  status_in = ffpa_pkg::STATUS_NO_FIT;
                  offset_in = '0;
               end
               if (step_flags.whole) begin
                  ram_we    = 1'b1;
                  ram_waddr = idx_ff;
                  ram_wdata = {1'b1, ram_rdata[SW-1:0]};
                  state_in  = ST_DONE;
               end else if (step_flags.split_oob) begin
                  status_in = ffpa_pkg::STATUS_NO_FIT;
                  offset_in = '0;
                  state_in  = ST_DONE;
               end else begin
                  tail_in  = step_tail;
                  k_in     = count_ff[IW-1:0];
                  state_in = (count_ff > next_idx) ? ST_SH_RD : ST_TAIL;
               end
            end else if (step_flags.stop) begin
               status_in = ffpa_pkg::STATUS_NO_FIT;
               offset_in = '0;
               state_in  = ST_DONE;
            end else begin
               idx_in = next_idx[IW-1:0];
               pos_in = step_next_pos;
            end
         end
         ST_SH_RD: begin
            ram_raddr = k_dec[IW-1:0];
            state_in  = ST_SH_WR;
         end
         ST_SH_WR: begin
            ram_we    = 1'b1;
            ram_waddr = k_ff;
            ram_wdata = ram_rdata;
            k_in      = k_dec[IW-1:0];
            state_in  = (k_dec > next_idx) ? ST_SH_RD : ST_TAIL;
         end
         ST_TAIL: begin
            ram_we    = 1'b1;
            ram_waddr = next_idx[IW-1:0];
            ram_wdata = {1'b0, tail_ff};
            state_in  = ST_HEAD;
         end
         ST_HEAD: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = {1'b1, need_ff};
            count_in  = count_ff + CW'(1);
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_off_in    = offset_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      k_ff          <= k_in;
      pos_ff        <= pos_in;
      need_ff       <= need_in;
      tail_ff       <= tail_in;
      status_ff     <= status_in;
      offset_ff     <= offset_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data_offset = rsp_off_ff;

endmodule

/* hdl/ffpa_checker.sv */
// Port-level checker for the first-fit pool allocator and its bind.
module ffpa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [ffpa_pkg::STATUS_W-1:0] rsp_status,
   input logic [ffpa_pkg::OFFSET_W-1:0] rsp_data_offset
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_data_offset))
      else $error("stalled response changed");

   // refused requests carry no offset
   a_no_grant_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ffpa_pkg::STATUS_GRANTED) |-> rsp_data_offset == '0)
      else $error("offset set on a refused request");

   // one request in flight at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // table initialization blocks requests right after reset
   a_init_stall: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("request path open during table init");

endmodule

bind first_fit_pool_allocator ffpa_checker u_ffpa_checker (.*);

/* test/tb.sv */
// Testbench for the first-fit pool allocator: directed and random requests checked against a table model.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ffpa_pkg::*;

   localparam int POOL  = POOL_BYTES_DEF;
   localparam int HDR   = HEADER_BYTES_DEF;
   localparam int SLOTS = MAX_BLOCKS_DEF;

   typedef struct packed {
      status_type          status;
      logic [OFFSET_W-1:0] data_offset;
   } grant_t;

   logic                clock             = 1'b0;
   logic                reset             = 1'b1;
   logic                req_valid         = 1'b0;
   logic                req_stall;
   logic [REQ_W-1:0]    req_request_bytes = '0;
   logic                rsp_valid;
   logic                rsp_stall         = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [OFFSET_W-1:0] rsp_data_offset;

   // block table as the allocator should hold it
   logic [10:0] block_len   [SLOTS];
   logic        block_taken [SLOTS];
   int unsigned block_total;

   grant_t      pending_grants[$];
   grant_t      want;
   int unsigned mismatch_count = 0;
   bit          quiet = 1'b0;

   first_fit_pool_allocator DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_request_bytes (req_request_bytes),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_data_offset   (rsp_data_offset)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb: FAIL");
      $finish;
   end

   function automatic grant_t grant_first_fit(input logic [REQ_W-1:0] nbytes);
      grant_t      g;
      int unsigned need, addr, len, i, k;
      bit          done, blocked;
      g.status      = STATUS_NO_FIT;
      g.data_offset = '0;
      need    = 32'(nbytes);
      need    = (need + 32'd7) & ~32'd7;
      addr    = 0;
      done    = 1'b0;
      blocked = 1'b0;
      if (need == 0 || need > POOL) begin
         g.status = STATUS_BAD_SIZE;
      end else begin
         for (i = 0; i < block_total && i < SLOTS && !done; i++) begin
            if (addr + HDR > POOL) begin
               done = 1'b1;
            end else begin
               len = 32'(block_len[i]);
               if (!block_taken[i] && len >= need) begin
                  done = 1'b1;
                  if (len <= need + HDR || block_total >= SLOTS) begin
                     block_taken[i] = 1'b1;
                  end else if (addr + 2 * HDR + need > POOL) begin
                     blocked = 1'b1;
                  end else begin
                     // split: shift the tail of the table up, insert the free remainder
                     for (k = block_total; k > i + 1; k--) begin
                        block_len[k]   = block_len[k-1];
                        block_taken[k] = block_taken[k-1];
                     end
                     block_len[i+1]   = 11'(len - need - HDR);
                     block_taken[i+1] = 1'b0;
                     block_len[i]     = 11'(need);
                     block_taken[i]   = 1'b1;
                     block_total++;
                  end
                  if (!blocked && addr + HDR + need <= POOL) begin
                     g.status      = STATUS_GRANTED;
                     g.data_offset = OFFSET_W'(addr + HDR);
                  end
               end else begin
                  addr += HDR + len;
               end
            end
         end
      end
      return g;
   endfunction

   function automatic void log_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("tb: mismatch at %0t: %s", $realtime, msg);
   endfunction

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 15);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_grants.size() == 0) begin
            log_mismatch($sformatf("unexpected transfer, status %0d offset %0d",
                                   rsp_status, rsp_data_offset));
         end else begin
            want = pending_grants.pop_front();
            if (rsp_status !== want.status)
               log_mismatch($sformatf("status expected %0d got %0d",
                                      want.status, rsp_status));
            if (rsp_data_offset !== want.data_offset)
               log_mismatch($sformatf("data_offset expected %0d got %0d",
                                      want.data_offset, rsp_data_offset));
         end
      end
   end

   task automatic send_request(input logic [REQ_W-1:0] nbytes);
      if (!quiet)
         while ($urandom_range(99) < 15) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      req_valid         <= 1'b1;
      req_request_bytes <= nbytes;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      pending_grants.push_back(grant_first_fit(nbytes));
   endtask

   // zero, sizes that round past the pool, all-ones
   task automatic test_bad_sizes;
      send_request(16'd0);
      send_request(16'hFFFF);
      send_request(16'd1025);
      send_request(16'h8000);
      send_request(16'hFFF8);
   endtask

   // legal sizes larger than the one free block
   task automatic test_no_fit;
      send_request(16'd1024);
      send_request(16'd1017);
      send_request(16'd1001);
   endtask

   // rounding to 8 bytes at the boundaries, each grant splits the free block
   task automatic test_rounding_split;
      logic [REQ_W-1:0] sizes [9] = '{16'd1, 16'd7, 16'd8, 16'd9, 16'd15,
                                      16'd16, 16'd17, 16'd24, 16'd25};
      foreach (sizes[j]) send_request(sizes[j]);
   endtask

   // mostly small sizes so the table fills up, then runs into the full pool
   task automatic test_random_requests(input int unsigned n);
      int unsigned      roll;
      logic [REQ_W-1:0] nbytes;
      repeat (n) begin
         roll = $urandom_range(99);
         if (roll < 60)      nbytes = REQ_W'($urandom_range(1, 24));
         else if (roll < 75) nbytes = REQ_W'($urandom_range(25, 200));
         else if (roll < 85) nbytes = REQ_W'($urandom_range(990, 1040));
         else                nbytes = REQ_W'($urandom_range(0, 65535));
         send_request(nbytes);
      end
   endtask

   initial begin
      foreach (block_len[j]) begin
         block_len[j]   = '0;
         block_taken[j] = 1'b0;
      end
      block_len[0] = 11'(POOL - HDR);
      block_total  = 1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      quiet = 1'b1;
      test_bad_sizes();
      test_no_fit();
      test_rounding_split();
      quiet = 1'b0;
      test_random_requests(1000);
      quiet = 1'b1;
      test_random_requests(300);
      quiet = 1'b0;
      test_random_requests(680);
      req_valid <= 1'b0;

      while (pending_grants.size() != 0) @(posedge clock);
      repeat (4 * SLOTS) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

/* filelist.f */
hdl/ffpa_pkg.sv
hdl/ffpa_ram.sv
hdl/ffpa_step.sv
hdl/first_fit_pool_allocator.sv
hdl/ffpa_checker.sv
test/tb.sv
